FILE: rtl/qrm_pkg.sv
// Shared widths, constants and pipeline word types for the quaternion to matrix block.
package qrm_pkg;

    localparam int QUAT_W  = 16;
    localparam int PROD_W  = 2 * QUAT_W;
    localparam int N_W     = PROD_W + 1;
    localparam int NUM_W   = PROD_W + 2;
    localparam int DIV_W   = N_W + 1;
    localparam int QUO_W   = 15;
    localparam int REM_W   = 48;
    localparam int NLANE   = 9;
    localparam int OUT_W   = 16;
    localparam int THR_W   = 10;
    localparam int ONE_Q14 = 16384;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

    localparam int ADDR_W = 3;
    localparam logic [0:0] REG_SNAP = 1'b0;

    typedef struct packed {
        logic             neg;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic                  valid;
        logic                  zero;
        logic [DIV_W-1:0]      dvs;
        lane_t [NLANE-1:0]     lane;
    } div_word_t;

endpackage

FILE: rtl/qrm_front.sv
// Front stages: products, quadrance and numerators, then dividend setup.
module qrm_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [qrm_pkg::QUAT_W-1:0] quat_w,
    input  logic signed [qrm_pkg::QUAT_W-1:0] quat_x,
    input  logic signed [qrm_pkg::QUAT_W-1:0] quat_y,
    input  logic signed [qrm_pkg::QUAT_W-1:0] quat_z,
    output qrm_pkg::div_word_t              word_out
);
    import qrm_pkg::*;

    logic valid_a_reg, valid_b_reg;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, xw_reg, yz_reg, yw_reg, zw_reg;
    logic [N_W-1:0]              n_reg, n_next;
    logic signed [NUM_W-1:0]     num_reg  [NLANE];
    logic signed [NUM_W-1:0]     num_next [NLANE];
    div_word_t                   word_reg, word_next;

    // stage A: ten products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
        end
        if (en) begin
            ww_reg <= quat_w * quat_w;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            xw_reg <= quat_x * quat_w;
            yz_reg <= quat_y * quat_z;
            yw_reg <= quat_y * quat_w;
            zw_reg <= quat_z * quat_w;
        end
    end

    // stage B: quadrance and numerators
    always_comb begin
        n_next = N_W'($unsigned(ww_reg)) + N_W'($unsigned(xx_reg))
               + N_W'($unsigned(yy_reg)) + N_W'($unsigned(zz_reg));
        num_next[0] = NUM_W'(ww_reg) + NUM_W'(xx_reg) - NUM_W'(yy_reg) - NUM_W'(zz_reg);
        num_next[1] = (NUM_W'(xy_reg) + NUM_W'(zw_reg)) <<< 1;
        num_next[2] = (NUM_W'(xz_reg) - NUM_W'(yw_reg)) <<< 1;
        num_next[3] = (NUM_W'(xy_reg) - NUM_W'(zw_reg)) <<< 1;
        num_next[4] = NUM_W'(ww_reg) - NUM_W'(xx_reg) + NUM_W'(yy_reg) - NUM_W'(zz_reg);
        num_next[5] = (NUM_W'(yz_reg) + NUM_W'(xw_reg)) <<< 1;
        num_next[6] = (NUM_W'(xz_reg) + NUM_W'(yw_reg)) <<< 1;
        num_next[7] = (NUM_W'(yz_reg) - NUM_W'(xw_reg)) <<< 1;
        num_next[8] = NUM_W'(ww_reg) - NUM_W'(xx_reg) - NUM_W'(yy_reg) + NUM_W'(zz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_b_reg <= valid_a_reg;
        end
        if (en) begin
            n_reg <= n_next;
            for (int k = 0; k < NLANE; k++) begin
                num_reg[k] <= num_next[k];
            end
        end
    end

    // stage C: magnitude, rounded dividend, doubled divisor
    always_comb begin
        logic [NUM_W-1:0] mag;
        word_next       = word_reg;
        word_next.valid = valid_b_reg;
        word_next.zero  = (n_reg == '0);
        word_next.dvs   = DIV_W'(n_reg) << 1;
        for (int k = 0; k < NLANE; k++) begin
            mag = num_reg[k][NUM_W-1] ? NUM_W'(-num_reg[k]) : NUM_W'(num_reg[k]);
            word_next.lane[k].neg = num_reg[k][NUM_W-1];
            word_next.lane[k].rem = (REM_W'(mag) << (QUO_W)) + REM_W'(n_reg);
            word_next.lane[k].quo = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (en) begin
            word_reg.valid <= word_next.valid;
        end
        if (en) begin
            word_reg.zero <= word_next.zero;
            word_reg.dvs  <= word_next.dvs;
            word_reg.lane <= word_next.lane;
        end
    end

    assign word_out = word_reg;

endmodule

FILE: rtl/qrm_div_step.sv
// One restoring division stage: settles one quotient bit in all nine lanes.
module qrm_div_step #(
    parameter int BIT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  qrm_pkg::div_word_t word_in,
    output qrm_pkg::div_word_t word_out
);
    import qrm_pkg::*;

    div_word_t word_reg, word_next;

    always_comb begin
        logic [REM_W-1:0] trial;
        word_next = word_in;
        trial     = REM_W'(word_in.dvs) << BIT;
        for (int k = 0; k < NLANE; k++) begin
            if (word_in.lane[k].rem >= trial) begin
                word_next.lane[k].rem      = word_in.lane[k].rem - trial;
                word_next.lane[k].quo[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg.valid <= 1'b0;
        end else if (en) begin
            word_reg.valid <= word_next.valid;
        end
        if (en) begin
            word_reg.zero <= word_next.zero;
            word_reg.dvs  <= word_next.dvs;
            word_reg.lane <= word_next.lane;
        end
    end

    assign word_out = word_reg;

endmodule

FILE: rtl/quaternion_to_rotation_matrix.sv
// Top level: quaternion in, normalized 3x3 rotation matrix out, fully pipelined.
//
// Input channel s_*: one word carries a quaternion (w, x, y, z), signed Q3.12.
// Output channel m_*: one word carries the nine entries m00..m22, signed Q1.14,
// plus zero_input, set when the quaternion is all zero (entries are then 0).
// Each entry is round(num * 2^14 / n), halves away from zero, with n the
// quadrance; magnitudes below snap_threshold LSBs are forced to zero.
// APB register 0 (any address with paddr[2] low): snap_threshold, 10 bits, reset value 2.
// Write it only while the pipeline is empty.
// Pipeline: 19 register stages (3 front stages for the multipliers, sums and
// dividend setup, 15 divider stages at one quotient bit each, one output stage
// that clamps, snaps and applies the sign); the accepting edge loads the first
// of them.
// Throughput: one word per cycle unless the output stalls; the 15-stage divider chain is fully pipelined.
// Reset: synchronous, active low; clears all valid bits and sets the threshold to 2.
// Stall: while m_valid is high and m_ready low the whole pipeline holds and
// s_ready drops; otherwise every stage advances by one each cycle.
module quaternion_to_rotation_matrix (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qrm_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [qrm_pkg::QUAT_W-1:0] s_quat_w,
    input  logic signed [qrm_pkg::QUAT_W-1:0] s_quat_x,
    input  logic signed [qrm_pkg::QUAT_W-1:0] s_quat_y,
    input  logic signed [qrm_pkg::QUAT_W-1:0] s_quat_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m00,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m01,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m02,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m10,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m11,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m12,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m20,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m21,
    output logic signed [qrm_pkg::OUT_W-1:0]  m_m22,
    output logic                              m_zero_input
);
    import qrm_pkg::*;

    logic [THR_W-1:0] thr_reg;
    logic             en;
    div_word_t        chain [QUO_W+1];

    logic                   m_valid_reg;
    logic                   zero_reg, zero_next;
    logic [OUT_W-1:0]       ent_reg  [NLANE];
    logic [OUT_W-1:0]       ent_next [NLANE];

    // config port: always ready, write on access phase
    assign pready = 1'b1;
    assign prdata = 32'(thr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SNAP)) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // advance everything together unless the output word is stuck
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    qrm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .quat_w   (s_quat_w),
        .quat_x   (s_quat_x),
        .quat_y   (s_quat_y),
        .quat_z   (s_quat_z),
        .word_out (chain[0])
    );

    // quotient bits from the top down, one per stage
    for (genvar i = 0; i < QUO_W; i++) begin : g_div
        qrm_div_step #(
            .BIT (QUO_W - 1 - i)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    // clamp, snap small entries, restore the sign
    always_comb begin
        logic [QUO_W-1:0] q;
        zero_next = chain[QUO_W].zero;
        for (int k = 0; k < NLANE; k++) begin
            q = chain[QUO_W].lane[k].quo;
            if (q > QUO_W'(ONE_Q14)) begin
                q = QUO_W'(ONE_Q14);
            end
            if (q < QUO_W'(thr_reg)) begin
                q = '0;
            end
            if (chain[QUO_W].zero) begin
                ent_next[k] = '0;
            end else if (chain[QUO_W].lane[k].neg) begin
                ent_next[k] = OUT_W'(-OUT_W'(q));
            end else begin
                ent_next[k] = OUT_W'(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= chain[QUO_W].valid;
        end
        if (en) begin
            zero_reg <= zero_next;
            for (int k = 0; k < NLANE; k++) begin
                ent_reg[k] <= ent_next[k];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_zero_input = zero_reg;
    assign m_m00 = ent_reg[0];
    assign m_m01 = ent_reg[1];
    assign m_m02 = ent_reg[2];
    assign m_m10 = ent_reg[3];
    assign m_m11 = ent_reg[4];
    assign m_m12 = ent_reg[5];
    assign m_m20 = ent_reg[6];
    assign m_m21 = ent_reg[7];
    assign m_m22 = ent_reg[8];

endmodule

FILE: bench/qrm_checker.sv
// Checker: predicts each rotation matrix from accepted quaternions and compares results.
module qrm_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qrm_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    input  logic                              pready,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [15:0]                s_quat_w,
    input  logic signed [15:0]                s_quat_x,
    input  logic signed [15:0]                s_quat_y,
    input  logic signed [15:0]                s_quat_z,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [15:0]                m_m00,
    input  logic signed [15:0]                m_m01,
    input  logic signed [15:0]                m_m02,
    input  logic signed [15:0]                m_m10,
    input  logic signed [15:0]                m_m11,
    input  logic signed [15:0]                m_m12,
    input  logic signed [15:0]                m_m20,
    input  logic signed [15:0]                m_m21,
    input  logic signed [15:0]                m_m22,
    input  logic                              m_zero_input,
    output int                                fail_count,
    output int                                pending
);
    import qrm_pkg::*;

    typedef struct {
        logic signed [15:0] e [9];
        logic               zero;
    } matrix_t;

    matrix_t              matrix_q [$];
    logic [THR_W-1:0]     snap_thr;

    function automatic logic signed [15:0] ratio_q14(longint num, longint quad,
                                                     logic [THR_W-1:0] thr);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = ((mag <<< 15) + quad) / (quad <<< 1);
        if (q > ONE_Q14) q = ONE_Q14;
        if (q < thr) q = 0;
        return (num < 0) ? 16'(-q) : 16'(q);
    endfunction

    function automatic matrix_t rotation_of(longint w, longint x, longint y, longint z,
                                            logic [THR_W-1:0] thr);
        matrix_t r;
        longint quad;
        longint num [9];
        quad = w*w + x*x + y*y + z*z;
        r.zero = (quad == 0);
        num[0] = w*w + x*x - y*y - z*z;
        num[1] = 2 * (x*y + z*w);
        num[2] = 2 * (x*z - y*w);
        num[3] = 2 * (x*y - z*w);
        num[4] = w*w - x*x + y*y - z*z;
        num[5] = 2 * (y*z + x*w);
        num[6] = 2 * (x*z + y*w);
        num[7] = 2 * (y*z - x*w);
        num[8] = w*w - x*x - y*y + z*z;
        for (int k = 0; k < 9; k++)
            r.e[k] = r.zero ? 16'sd0 : ratio_q14(num[k], quad, thr);
        return r;
    endfunction

    always @(posedge aclk) begin
        logic signed [15:0] got [9];
        matrix_t exp_m;
        int errs;
        errs = 0;
        if (!aresetn) begin
            snap_thr <= THR_RESET;
            fail_count <= 0;
            matrix_q.delete();
            pending <= 0;
        end else begin
            // Track the threshold the block will apply.
            if (psel && penable && pwrite && pready && paddr == ADDR_W'(0))
                snap_thr <= pwdata[THR_W-1:0];
            if (s_valid && s_ready)
                matrix_q.push_back(rotation_of(s_quat_w, s_quat_x, s_quat_y, s_quat_z,
                                               snap_thr));
            if (m_valid && m_ready) begin
                got = '{m_m00, m_m01, m_m02, m_m10, m_m11, m_m12, m_m20, m_m21, m_m22};
                if (matrix_q.size() == 0) begin
                    $error("result word with no quaternion outstanding");
                    errs = errs + 1;
                end else begin
                    exp_m = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== exp_m.e[k]) begin
                            $error("m%0d%0d expected %0d got %0d", k / 3, k % 3,
                                   exp_m.e[k], got[k]);
                            errs = errs + 1;
                        end
                    if (m_zero_input !== exp_m.zero) begin
                        $error("zero_input expected %0d got %0d", exp_m.zero, m_zero_input);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= matrix_q.size();
        end
    end
endmodule

FILE: bench/tb.sv
// Testbench top: drives quaternions and threshold writes, gives the verdict.
module tb;
    import qrm_pkg::*;

    localparam int LATENCY    = 19;
    localparam int IDLE_LIMIT = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0, s_ready;
    logic signed [15:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic m_valid, m_ready = 1'b0;
    logic signed [15:0] m_m00, m_m01, m_m02, m_m10, m_m11, m_m12, m_m20, m_m21, m_m22;
    logic m_zero_input;
    int fail_count, pending;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    always #5 aclk = ~aclk;

    quaternion_to_rotation_matrix dut (.*);

    qrm_checker chk (.*);

    // Pick a gap: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Hold off the output side at random, with quiet stretches of full speed.
    int stall_left = 0;
    int burst_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left <= burst_left - 1;
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            burst_left <= $urandom_range(20, 80);
            m_ready <= 1'b1;
        end else begin
            stall_left <= gap_len();
            m_ready <= 1'b1;
        end
    end

    // Watchdog: count cycles without any handshake.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_snap(input logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_W'(0); pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain: wait until every matrix is back, then let the pipe settle.
    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic send_quat(input logic [15:0] w, x, y, z);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_quat_w <= w; s_quat_x <= x; s_quat_y <= y; s_quat_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Random quaternion: mostly full range, some small or near-unit, some sparse.
    task automatic send_random();
        logic [15:0] q [4];
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++) begin
            case (mode)
                0, 1: begin
                    q[k] = 16'($signed($urandom_range(0, 8)) - 4);
                end
                2: begin
                    q[k] = ($urandom_range(0, 1)) ? 16'($urandom) : 16'h0000;
                end
                3: begin
                    q[k] = (k == 0) ? 16'sd4096 : 16'($signed($urandom_range(0, 200)) - 100);
                end
                default: begin
                    q[k] = 16'($urandom);
                end
            endcase
        end
        send_quat(q[0], q[1], q[2], q[3]);
    endtask

    initial begin
        logic [15:0] dir [][4];
        logic [31:0] thr_set [];
        dir = '{
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd4096, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd4096, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd4096, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd4096},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
            '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
            '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
            '{16'h8000, 16'h0000, 16'h0000, 16'h0000},
            '{16'sd1, 16'sd0, 16'sd0, 16'sd0},
            '{16'sd0, 16'sd0, 16'sd0, -16'sd1},
            '{16'sd1, 16'sd1, 16'sd1, 16'sd1},
            '{16'sd2896, 16'sd2896, 16'sd0, 16'sd0},
            '{16'sd4096, 16'sd1, 16'sd0, 16'sd0},
            '{16'sd4096, 16'sd3, 16'sd5, -16'sd7},
            '{-16'sd4096, 16'sd1000, -16'sd2000, 16'sd3000},
            '{16'hFFFF, 16'h7FFF, 16'h0001, 16'h8001},
            '{16'sd0, 16'h5555, 16'hAAAA, 16'sd0}
        };
        thr_set = '{32'd0, 32'd1023, 32'd1, 32'd512, 32'hFFFF_FC02, 32'd7};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset threshold.
        foreach (dir[i]) send_quat(dir[i][0], dir[i][1], dir[i][2], dir[i][3]);
        s_valid <= 1'b0;
        drain();

        // Random phases, one threshold each, extremes among them; the first also repeats the directed set.
        foreach (thr_set[p]) begin
            write_snap(thr_set[p]);
            if (p == 0)
                foreach (dir[i]) send_quat(dir[i][0], dir[i][1], dir[i][2], dir[i][3]);
            repeat (190) send_random();
            s_valid <= 1'b0;
            drain();
        end

        stim_done = 1'b1;
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
